>>> sv/median_filter_5x5_defines.svh
// Assertion macros for the median_filter_5x5 block.
// No dependencies; included by files that carry assertions.
`ifndef MEDIAN_FILTER_5X5_DEFINES_SVH
`define MEDIAN_FILTER_5X5_DEFINES_SVH

// cond must never hold outside reset
`define MF5_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

// when ante holds, cons must hold in the same cycle
`define MF5_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication failed");

`endif

>>> sv/mf5_pkg.sv
// Shared types and constants of the 5x5 median filter.
// No dependencies.
package mf5_pkg;
   localparam int PIX_W      = 8;
   localparam int CSR_W      = 11;
   localparam int SIZE_W     = CSR_W + 1;    // counters run past the height in the flush
   localparam int WIN        = 5;
   localparam int HALF       = WIN / 2;
   localparam int NUM_LINES  = WIN - 1;
   localparam int WIN_AREA   = WIN * WIN;
   localparam int MED_POS    = WIN_AREA / 2;
   localparam int CENTER     = HALF * WIN + HALF;
   localparam int MIN_SIZE   = 5;
   localparam int RESET_SIZE = 512;
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int FIFO_DEPTH = 8;

   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   typedef logic [WIN_AREA-1:0][PIX_W-1:0] win_type;

   typedef struct packed {
      logic valid;
      logic border;
      logic last;
   } ctl_type;
endpackage

>>> sv/mf5_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mf5_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> sv/mf5_front.sv
// Front end: classifies items, keeps input/output positions, the line
// store and the 5x5 window. Depends on mf5_pkg and mf5_ram.
module mf5_front import mf5_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              restart,
   input  logic [SIZE_W-1:0] image_width,
   input  logic [SIZE_W-1:0] image_height,
   input  logic              req_take,
   input  logic              op,
   input  logic [PIX_W-1:0]  pixel_in,
   output logic              emit_take,
   output ctl_type           task_o,
   output win_type           win_o
);
   localparam int AW = $clog2(MAX_WIDTH);
   localparam int LW = NUM_LINES * PIX_W;

   logic [SIZE_W-1:0] in_col_ff, in_col_in, in_row_ff, in_row_in;
   logic [SIZE_W-1:0] out_col_ff, out_col_in, out_row_ff, out_row_in;
   logic              take, emit, border, last;
   logic [PIX_W-1:0]  px;

   logic              s1_valid_ff;
   ctl_type           s1_ctl_ff;
   logic [PIX_W-1:0]  s1_px_ff;
   logic [AW-1:0]     s1_col_ff;
   logic [LW-1:0]     rd_lines;

   win_type           win_ff;
   ctl_type           task_ff;

   // only items matching the phase (pixel in frame, flush after) do anything
   assign take   = req_take && (op == (in_row_ff >= image_height));
   assign px     = op ? '0 : pixel_in;
   assign emit   = (in_row_ff > SIZE_W'(HALF)) ||
                   (in_row_ff == SIZE_W'(HALF) && in_col_ff >= SIZE_W'(HALF));
   assign border = (out_row_ff < SIZE_W'(HALF)) ||
                   (out_row_ff >= image_height - SIZE_W'(HALF)) ||
                   (out_col_ff < SIZE_W'(HALF)) ||
                   (out_col_ff >= image_width - SIZE_W'(HALF));
   assign last   = (out_row_ff == image_height - SIZE_W'(1)) &&
                   (out_col_ff == image_width - SIZE_W'(1));
   assign emit_take = take && emit;

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (restart) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (take) begin
         if (in_col_ff + SIZE_W'(1) >= image_width) begin
            in_col_in = '0;
            in_row_in = in_row_ff + SIZE_W'(1);
         end else begin
            in_col_in = in_col_ff + SIZE_W'(1);
         end
         if (emit) begin
            if (last) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if (out_col_ff + SIZE_W'(1) >= image_width) begin
               out_col_in = '0;
               out_row_in = out_row_ff + SIZE_W'(1);
            end else begin
               out_col_in = out_col_ff + SIZE_W'(1);
            end
         end
      end
   end

   // each entry holds one column of the four older lines, newest in the low byte
   mf5_ram #(.WIDTH(LW), .DEPTH(MAX_WIDTH)) u_lines (
      .clock (clock),
      .we    (s1_valid_ff),
      .waddr (s1_col_ff),
      .wdata ({rd_lines[LW-PIX_W-1:0], s1_px_ff}),
      .raddr (in_col_ff[AW-1:0]),
      .rdata (rd_lines)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         s1_valid_ff <= 1'b0;
         task_ff     <= '0;
      end else begin
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         s1_valid_ff <= take;
         task_ff     <= '{valid: s1_valid_ff && s1_ctl_ff.valid,
                          border: s1_ctl_ff.border, last: s1_ctl_ff.last};
      end
      s1_ctl_ff <= '{valid: emit, border: border, last: last};
      s1_px_ff  <= px;
      s1_col_ff <= in_col_ff[AW-1:0];
      if (reset) begin
         win_ff <= '0;
      end else if (s1_valid_ff) begin
         for (int a = WIN - 1; a > 0; a--) begin
            for (int k = 0; k < WIN; k++) begin
               win_ff[a*WIN + k] <= win_ff[(a-1)*WIN + k];
            end
         end
         win_ff[0] <= s1_px_ff;
         for (int k = 1; k < WIN; k++) begin
            win_ff[k] <= rd_lines[(k-1)*PIX_W +: PIX_W];
         end
      end
   end

   assign task_o = task_ff;
   assign win_o  = win_ff;
endmodule

>>> sv/mf5_back.sv
// Back end: rank-based median of the 25-pixel window in three stages,
// or the center pixel at the border. Depends on mf5_pkg.
module mf5_back import mf5_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  ctl_type          task_i,
   input  win_type          win_i,
   output ctl_type          res_o,
   output logic [PIX_W-1:0] pixel_o
);
   localparam int CNT_W = $clog2(WIN_AREA + 1);

   logic [WIN_AREA-1:0][WIN_AREA-1:0] lt_ff;
   win_type                           win_a_ff, win_b_ff;
   ctl_type                           ctl_a_ff, ctl_b_ff, res_ff;
   logic [WIN_AREA-1:0][CNT_W-1:0]    rank;
   logic [WIN_AREA-1:0]               sel_ff;
   logic [PIX_W-1:0]                  pick, pixel_ff;

   // ties are broken by position, so exactly one pixel has the median rank
   always_comb begin
      for (int i = 0; i < WIN_AREA; i++) begin
         rank[i] = '0;
         for (int j = 0; j < WIN_AREA; j++) begin
            rank[i] = rank[i] + CNT_W'(lt_ff[i][j]);
         end
      end
   end

   always_comb begin
      pick = '0;
      for (int i = 0; i < WIN_AREA; i++) begin
         if (sel_ff[i]) begin
            pick = pick | win_b_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
         ctl_b_ff <= '0;
         res_ff   <= '0;
      end else begin
         ctl_a_ff <= task_i;
         ctl_b_ff <= ctl_a_ff;
         res_ff   <= ctl_b_ff;
      end
      for (int i = 0; i < WIN_AREA; i++) begin
         for (int j = 0; j < WIN_AREA; j++) begin
            lt_ff[i][j] <= (j < i) ? (win_i[j] <= win_i[i]) : (win_i[j] < win_i[i]);
         end
         sel_ff[i] <= (rank[i] == CNT_W'(MED_POS));
      end
      win_a_ff <= win_i;
      win_b_ff <= win_a_ff;
      pixel_ff <= ctl_b_ff.border ? win_b_ff[CENTER] : pick;
   end

   assign res_o   = res_ff;
   assign pixel_o = pixel_ff;
endmodule

>>> sv/median_filter_5x5.sv
// Streaming 5x5 median filter: takes one pixel or flush item per clock and
// passes each result through the front-end and back-end registers into a
// result queue of 8 items; req_full rises while 8 results are owed, so the
// rate is one item per clock as long as rsp_pop keeps up. Results lag the
// input by two rows and two pixels; 2*width+2 flush items end a frame.
`include "median_filter_5x5_defines.svh"
module median_filter_5x5 import mf5_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic             req_op,
   input  logic [PIX_W-1:0] req_pixel_in,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [PIX_W-1:0] rsp_pixel_out,
   output logic             rsp_passed_through,
   output logic             rsp_last_of_frame,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);
   localparam int FAW = $clog2(FIFO_DEPTH);
   localparam int FCW = $clog2(FIFO_DEPTH + 1);

   logic [SIZE_W-1:0] width_ff, height_ff, clamp_w, clamp_h;
   logic              emit_take, do_pop;
   ctl_type           task_c, res_c;
   win_type           win_c;
   logic [PIX_W-1:0]  res_pixel;

   logic [PIX_W-1:0]  fifo_pix_ff [FIFO_DEPTH];
   logic              fifo_brd_ff [FIFO_DEPTH];
   logic              fifo_last_ff[FIFO_DEPTH];
   logic [FAW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [FCW-1:0]    fcnt_ff, cred_ff;

   always_comb begin
      clamp_w = SIZE_W'(csr_wdata);
      clamp_h = SIZE_W'(csr_wdata);
      if (32'(csr_wdata) < MIN_SIZE) begin
         clamp_w = SIZE_W'(MIN_SIZE);
         clamp_h = SIZE_W'(MIN_SIZE);
      end else begin
         if (32'(csr_wdata) > MAX_WIDTH) clamp_w = SIZE_W'(MAX_WIDTH);
         if (32'(csr_wdata) > MAX_HEIGHT) clamp_h = SIZE_W'(MAX_HEIGHT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SIZE_W'(RESET_SIZE);
         height_ff <= SIZE_W'(RESET_SIZE);
      end else if (csr_we) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  width_ff  <= clamp_w;
            REG_IMAGE_HEIGHT: height_ff <= clamp_h;
            default:          width_ff  <= width_ff;
         endcase
      end
   end

   mf5_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock        (clock),
      .reset        (reset),
      .restart      (csr_we),
      .image_width  (width_ff),
      .image_height (height_ff),
      .req_take     (req_push && !req_full),
      .op           (req_op),
      .pixel_in     (req_pixel_in),
      .emit_take    (emit_take),
      .task_o       (task_c),
      .win_o        (win_c)
   );

   mf5_back u_back (
      .clock   (clock),
      .reset   (reset),
      .task_i  (task_c),
      .win_i   (win_c),
      .res_o   (res_c),
      .pixel_o (res_pixel)
   );

   // a credit is taken for every accepted item that will make a result
   assign do_pop   = rsp_pop && !rsp_empty;
   assign req_full = (cred_ff == FCW'(FIFO_DEPTH));
   assign rsp_empty = (fcnt_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fcnt_ff   <= '0;
         cred_ff   <= '0;
      end else begin
         if (res_c.valid) wr_ptr_ff <= wr_ptr_ff + FAW'(1);
         if (do_pop)      rd_ptr_ff <= rd_ptr_ff + FAW'(1);
         fcnt_ff <= fcnt_ff + FCW'(res_c.valid) - FCW'(do_pop);
         cred_ff <= cred_ff + FCW'(emit_take) - FCW'(do_pop);
      end
      if (res_c.valid) begin
         fifo_pix_ff[wr_ptr_ff]  <= res_pixel;
         fifo_brd_ff[wr_ptr_ff]  <= res_c.border;
         fifo_last_ff[wr_ptr_ff] <= res_c.last;
      end
   end

   assign rsp_pixel_out      = fifo_pix_ff[rd_ptr_ff];
   assign rsp_passed_through = fifo_brd_ff[rd_ptr_ff];
   assign rsp_last_of_frame  = fifo_last_ff[rd_ptr_ff];

   `MF5_NEVER(a_no_overflow, clock, reset, res_c.valid && fcnt_ff == FCW'(FIFO_DEPTH) && !do_pop)
   `MF5_NEVER(a_cred_covers, clock, reset, cred_ff < fcnt_ff)
   `MF5_IMPLY(a_res_owed, clock, reset, res_c.valid, cred_ff != '0)
endmodule

>>> tb/tb_top.sv
// Self-checking testbench for median_filter_5x5: random and directed frames,
// predicted in place and compared item by item. Depends on mf5_pkg and the RTL.
`timescale 1ns / 100ps
module tb_top;
   import mf5_pkg::*;

   typedef struct {
      logic             op;
      logic [PIX_W-1:0] px;
   } pixel_item_type;

   typedef struct {
      logic [PIX_W-1:0] px;
      logic             border;
      logic             last;
   } filtered_type;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;
   localparam int   LINE_LEN = DEF_MAX_WIDTH;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_push = 1'b0;
   logic             req_full;
   logic             req_op = OP_PIXEL;
   logic [PIX_W-1:0] req_pixel_in = '0;
   logic             rsp_empty;
   logic             rsp_pop = 1'b0;
   logic [PIX_W-1:0] rsp_pixel_out;
   logic             rsp_passed_through;
   logic             rsp_last_of_frame;
   logic             csr_we = 1'b0;
   logic             csr_index = REG_IMAGE_WIDTH;
   logic [CSR_W-1:0] csr_wdata = '0;

   median_filter_5x5 u_top (.*);

   // predictor state
   int               frame_w = RESET_SIZE;
   int               frame_h = RESET_SIZE;
   logic [PIX_W-1:0] line_mem [NUM_LINES][LINE_LEN];
   logic [PIX_W-1:0] win_px [WIN][WIN];   // [column age][row age]
   int               col_in, row_in, col_out, row_out;

   pixel_item_type pixel_queue[$];
   filtered_type   filtered_queue[$];
   int             fail_count = 0;
   int             items_queued = 0;
   int             send_gap = 0;
   bit             send_idle = 1'b1;
   int             rcv_wait = 0;
   bit             rcv_idle = 1'b1;
   int             results_seen = 0;
   pixel_item_type drv_item;

   initial forever #5 clock = ~clock;

   initial begin
      #20_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic logic [PIX_W-1:0] window_median();
      logic [PIX_W-1:0] v [WIN_AREA];
      logic [PIX_W-1:0] x;
      int j;
      for (int a = 0; a < WIN; a++)
         for (int b = 0; b < WIN; b++)
            v[a * WIN + b] = win_px[a][b];
      for (int i = 1; i < WIN_AREA; i++) begin
         x = v[i];
         j = i;
         while (j > 0 && v[j - 1] > x) begin
            v[j] = v[j - 1];
            j--;
         end
         v[j] = x;
      end
      return v[MED_POS];
   endfunction

   function automatic void restart_counters();
      col_in = 0; row_in = 0; col_out = 0; row_out = 0;
   endfunction

   function automatic void filter_item(input logic op, input logic [PIX_W-1:0] px);
      logic [PIX_W-1:0] v;
      int c;
      bit emit;
      filtered_type r;
      if (op != (row_in >= frame_h)) return;   // out-of-phase item is ignored
      v = (op == OP_FLUSH) ? '0 : px;
      c = col_in % LINE_LEN;
      for (int a = WIN - 1; a > 0; a--) win_px[a] = win_px[a - 1];
      win_px[0][0] = v;
      for (int k = 1; k < WIN; k++) win_px[0][k] = line_mem[k - 1][c];
      for (int k = NUM_LINES - 1; k > 0; k--) line_mem[k][c] = line_mem[k - 1][c];
      line_mem[0][c] = v;
      emit = row_in > HALF || (row_in == HALF && col_in >= HALF);
      col_in++;
      if (col_in >= frame_w) begin
         col_in = 0;
         row_in++;
      end
      if (!emit) return;
      r.border = row_out < HALF || row_out >= frame_h - HALF ||
                 col_out < HALF || col_out >= frame_w - HALF;
      r.px = r.border ? win_px[HALF][HALF] : window_median();
      r.last = row_out == frame_h - 1 && col_out == frame_w - 1;
      filtered_queue = {filtered_queue, r};
      if (r.last) restart_counters();
      else begin
         col_out++;
         if (col_out >= frame_w) begin
            col_out = 0;
            row_out++;
         end
      end
   endfunction

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) filter_item(req_op, req_pixel_in);
         if (!(req_push && req_full)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_push <= 1'b0;
            end else if (pixel_queue.size() > 0) begin
               drv_item = pixel_queue.pop_front();
               req_push <= 1'b1;
               req_op <= drv_item.op;
               req_pixel_in <= drv_item.px;
               if ($urandom_range(0, 59) == 0) send_idle = !send_idle;
               send_gap = send_idle ? $urandom_range(0, 18) : 0;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      filtered_type e;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            results_seen++;
            if (filtered_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected item: px=%0d", rsp_pixel_out);
            end else begin
               e = filtered_queue.pop_front();
               if (e.px !== rsp_pixel_out || e.border !== rsp_passed_through ||
                   e.last !== rsp_last_of_frame) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: exp px=%0d brd=%0b last=%0b got px=%0d brd=%0b last=%0b",
                              e.px, e.border, e.last, rsp_pixel_out,
                              rsp_passed_through, rsp_last_of_frame);
               end
            end
            if ($urandom_range(0, 59) == 0) rcv_idle = !rcv_idle;
            // one long hold-off so the result queue fills and req_full rises
            if (results_seen == 60) rcv_wait = 400;
            else rcv_wait = rcv_idle ? $urandom_range(0, 18) : 0;
         end
         if (rcv_wait > 0) begin
            rcv_wait--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   task automatic wait_idle();
      do begin
         @(posedge clock);
         #1;
      end while (pixel_queue.size() != 0 || req_push || filtered_queue.size() != 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [CSR_W-1:0] value);
      int v;
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      v = int'(value);
      if (v < MIN_SIZE) v = MIN_SIZE;
      if (idx == REG_IMAGE_WIDTH) begin
         if (v > DEF_MAX_WIDTH) v = DEF_MAX_WIDTH;
         frame_w = v;
      end else begin
         if (v > DEF_MAX_HEIGHT) v = DEF_MAX_HEIGHT;
         frame_h = v;
      end
      restart_counters();
   endtask

   function automatic void queue_item(input logic op, input logic [PIX_W-1:0] px);
      pixel_item_type it;
      it.op = op;
      it.px = px;
      pixel_queue = {pixel_queue, it};
      items_queued++;
   endfunction

   // style: 0 random, 1 narrow range, 2 all zero, 3 all 255
   function automatic logic [PIX_W-1:0] draw_pixel(input int style);
      case (style)
         0: return PIX_W'($urandom_range(0, 255));
         1: return PIX_W'(120 + $urandom_range(0, 15));
         2: return 8'd0;
         default: return 8'd255;
      endcase
   endfunction

   // cut < 0 means whole frame plus flush; otherwise only that many pixels
   function automatic void queue_frame(input int w, input int h, input int style,
                                       input int cut, input bit noise);
      int n;
      n = (cut >= 0) ? cut : w * h;
      for (int i = 0; i < n; i++) begin
         if (noise && $urandom_range(0, 29) == 0)
            queue_item(OP_FLUSH, PIX_W'($urandom_range(0, 255)));
         queue_item(OP_PIXEL, draw_pixel(style));
      end
      if (cut >= 0) return;
      for (int i = 0; i < 2 * w + 2; i++) begin
         if (noise && $urandom_range(0, 19) == 0)
            queue_item(OP_PIXEL, PIX_W'($urandom_range(0, 255)));
         queue_item(OP_FLUSH, PIX_W'($urandom_range(0, 255)));
      end
   endfunction

   function automatic int clamp_dim(input int raw);
      return raw < MIN_SIZE ? MIN_SIZE : (raw > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : raw);
   endfunction

   initial begin
      int w_raw, h_raw;
      for (int a = 0; a < WIN; a++)
         for (int b = 0; b < WIN; b++)
            win_px[a][b] = '0;
      for (int k = 0; k < NUM_LINES; k++)
         for (int c = 0; c < LINE_LEN; c++)
            line_mem[k][c] = '0;
      restart_counters();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: smallest frame, extremes of pixel values, out-of-phase items
      write_reg(REG_IMAGE_WIDTH, 11'd0);
      write_reg(REG_IMAGE_HEIGHT, 11'd4);
      queue_item(OP_FLUSH, 8'hFF);            // flush inside the frame: ignored
      queue_frame(5, 5, 3, -1, 1'b0);
      wait_idle();
      queue_item(OP_PIXEL, 8'h00);
      queue_item(OP_PIXEL, 8'hFF);
      queue_item(OP_FLUSH, 8'h55);
      for (int i = 0; i < 12; i++) queue_item(OP_PIXEL, (i % 2) ? 8'hFF : 8'h00);
      wait_idle();
      // abandon a partial frame by a register write
      write_reg(REG_IMAGE_WIDTH, 11'd5);
      queue_frame(5, 5, 0, -1, 1'b1);
      wait_idle();

      // largest width, first part of a frame
      write_reg(REG_IMAGE_WIDTH, 11'd1024);
      write_reg(REG_IMAGE_HEIGHT, 11'd5);
      queue_frame(1024, 5, 0, 300, 1'b0);
      wait_idle();

      // tall frame cut short, height above range
      write_reg(REG_IMAGE_WIDTH, 11'd5);
      write_reg(REG_IMAGE_HEIGHT, 11'h7FF);
      queue_frame(5, 1024, 0, 150, 1'b1);
      wait_idle();

      while (items_queued < 1200) begin
         if ($urandom_range(0, 7) == 0) w_raw = $urandom_range(0, 2047) % 20;
         else w_raw = $urandom_range(5, 14);
         if ($urandom_range(0, 19) == 0) h_raw = $urandom_range(1025, 2047);
         else h_raw = $urandom_range(0, 11);
         write_reg(REG_IMAGE_WIDTH, CSR_W'(w_raw));
         write_reg(REG_IMAGE_HEIGHT, CSR_W'(h_raw));
         if (clamp_dim(h_raw) > 20)
            queue_frame(clamp_dim(w_raw), 20, 0, clamp_dim(w_raw) * 12, 1'b1);
         else if ($urandom_range(0, 9) == 0)
            queue_frame(clamp_dim(w_raw), clamp_dim(h_raw), 0,
                        $urandom_range(0, clamp_dim(w_raw) * clamp_dim(h_raw)), 1'b1);
         else begin
            queue_frame(clamp_dim(w_raw), clamp_dim(h_raw),
                        $urandom_range(0, 5) < 4 ? $urandom_range(0, 1) : $urandom_range(2, 3),
                        -1, $urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) == 0)   // back-to-back frame without a write
               queue_frame(clamp_dim(w_raw), clamp_dim(h_raw), 0, -1, 1'b0);
         end
         wait_idle();
      end

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
